// File: src/vau_pkg.sv
// ----------------------------------------------------------------------------
// Vector arithmetic unit package
// Command codes, the transaction record that travels down the pipeline and
// the shared saturation and magnitude helpers.
// ----------------------------------------------------------------------------
package vau_pkg;

  typedef enum logic [2:0] {
    CMD_ADD   = 3'd0,
    CMD_SUB   = 3'd1,
    CMD_MUL   = 3'd2,
    CMD_DIV   = 3'd3,
    CMD_CROSS = 3'd4,
    CMD_DOT   = 3'd5,
    CMD_LEN   = 3'd6,
    CMD_NORM  = 3'd7
  } vau_cmd_t;

  localparam logic [31:0] MAX32 = 32'h7fff_ffff;
  localparam logic [31:0] MIN32 = 32'h8000_0000;

  // One root bit per stage over a 64-bit radicand
  localparam int SQ_STAGES = 32;

  // Transaction record carried behind the front end
  typedef struct packed {
    vau_cmd_t         cmd;
    logic [3:0][31:0] r;        // results settled so far
    logic             dz;
    logic             ovf;
    logic [3:0]       dmask;    // lanes whose result comes from the divider
    logic [3:0]       num_neg;
    logic [3:0]       den_neg;
    logic [3:0][31:0] num_mag;
    logic [3:0][32:0] den_mag;
    logic             len_sel;  // r_x takes the rounded root
    logic             norm_sel; // divisors of lanes x..z take the rounded root
    logic [63:0]      sq_sum;
  } vau_item_t;

  typedef struct packed {
    logic [31:0] val;
    logic        ovf;
  } vau_sat_t;

  // Clip a wide signed value to the 32-bit range
  function automatic vau_sat_t vau_sat(input logic signed [66:0] v);
    vau_sat_t s;
    s.ovf = 1'b0;
    s.val = v[31:0];
    if (v > 67'sd2147483647) begin
      s.val = MAX32;
      s.ovf = 1'b1;
    end else if (v < -67'sd2147483648) begin
      s.val = MIN32;
      s.ovf = 1'b1;
    end
    return s;
  endfunction

  function automatic logic [31:0] vau_mag(input logic signed [31:0] v);
    logic signed [32:0] n;
    n = -(33'(v));
    return v[31] ? n[31:0] : v;
  endfunction

endpackage

// File: src/vector_arithmetic_unit.sv
// Throughput: one transaction per cycle unless stalled; every stage advances together.
// Most depth lies in the 32-stage square root and 32 + FRAC_BITS stage divider.
// A stall on the result side holds the whole pipeline; nothing is dropped.
// Reset (rst_n low, synchronous) clears all valid bits; data registers keep state.
// ----------------------------------------------------------------------------
// Vector arithmetic unit
// Q16.16 vector ALU: add, sub, mul, div, cross, dot, length and normalize.
// ----------------------------------------------------------------------------
module vector_arithmetic_unit import vau_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int LANES     = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_cmd,
  input  logic [2:0]  in_vec_size,
  input  logic        in_scalar_mode,
  input  logic [31:0] in_a_x,
  input  logic [31:0] in_a_y,
  input  logic [31:0] in_a_z,
  input  logic [31:0] in_a_w,
  input  logic [31:0] in_b_x,
  input  logic [31:0] in_b_y,
  input  logic [31:0] in_b_z,
  input  logic [31:0] in_b_w,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_r_x,
  output logic [31:0] out_r_y,
  output logic [31:0] out_r_z,
  output logic [31:0] out_r_w,
  output logic        out_div_zero,
  output logic        out_overflow
);

  localparam int DW = 32 + FRAC_BITS;

  logic                 en;
  logic                 fe_valid;
  vau_item_t            fe_item;
  logic                 sq_valid;
  vau_item_t            sq_item;
  logic [31:0]          sq_root;
  logic [33:0]          sq_rem;
  logic                 post_v_r;
  vau_item_t            post_r, post_nxt;
  logic                 dv_valid;
  vau_item_t            dv_item;
  logic [3:0][DW-1:0]   dv_quo;
  logic                 out_valid_r;
  logic [3:0][31:0]     res_r, res_nxt;
  logic                 dz_r, ovf_r, ovf_nxt;

  // Advance whenever the result register is free or being taken
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  vau_front #(
    .FRAC_BITS (FRAC_BITS),
    .LANES     (LANES)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (in_valid),
    .cmd         (in_cmd),
    .vec_size    (in_vec_size),
    .scalar_mode (in_scalar_mode),
    .a           ({in_a_w, in_a_z, in_a_y, in_a_x}),
    .b           ({in_b_w, in_b_z, in_b_y, in_b_x}),
    .out_valid   (fe_valid),
    .out_item    (fe_item)
  );

  vau_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fe_valid),
    .in_item   (fe_item),
    .out_valid (sq_valid),
    .out_item  (sq_item),
    .root      (sq_root),
    .rem       (sq_rem)
  );

  // Round the root; hand it to the length result or the normalize divisors
  always_comb begin
    logic [32:0] len;
    post_nxt = sq_item;
    len = {1'b0, sq_root} + 33'(sq_rem > {2'b00, sq_root});
    if (sq_item.len_sel) begin
      if (len > {1'b0, MAX32}) begin
        post_nxt.r[0] = MAX32;
        post_nxt.ovf  = 1'b1;
      end else begin
        post_nxt.r[0] = len[31:0];
      end
    end
    if (sq_item.norm_sel) begin
      for (int j = 0; j < 3; j++) begin
        post_nxt.den_mag[j] = len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      post_v_r <= 1'b0;
    end else if (en) begin
      post_v_r <= sq_valid;
    end
    if (en) begin
      post_r <= post_nxt;
    end
  end

  vau_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (post_v_r),
    .in_item   (post_r),
    .out_valid (dv_valid),
    .out_item  (dv_item),
    .quo       (dv_quo)
  );

  // Apply quotient signs and clip divider lanes
  always_comb begin
    logic [DW-1:0] q;
    logic [DW-1:0] qn;
    res_nxt = dv_item.r;
    ovf_nxt = dv_item.ovf;
    for (int j = 0; j < 4; j++) begin
      q  = dv_quo[j];
      qn = '0 - q;
      if (dv_item.dmask[j]) begin
        if (!(dv_item.num_neg[j] ^ dv_item.den_neg[j])) begin
          if (q > DW'(MAX32)) begin
            res_nxt[j] = MAX32;
            ovf_nxt    = 1'b1;
          end else begin
            res_nxt[j] = q[31:0];
          end
        end else begin
          if (q > DW'(MIN32)) begin
            res_nxt[j] = MIN32;
            ovf_nxt    = 1'b1;
          end else begin
            res_nxt[j] = qn[31:0];
          end
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_valid;
    end
    if (en) begin
      res_r <= res_nxt;
      dz_r  <= dv_item.dz;
      ovf_r <= ovf_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_r_x      = res_r[0];
  assign out_r_y      = res_r[1];
  assign out_r_z      = res_r[2];
  assign out_r_w      = res_r[3];
  assign out_div_zero = dz_r;
  assign out_overflow = ovf_r;

endmodule

// File: src/vau_front.sv
// ----------------------------------------------------------------------------
// Vector arithmetic unit front end
// Four stages: products, partial sums with elementwise results and divider
// set-up, totals with cross rounding, then dot rounding and root set-up.
// ----------------------------------------------------------------------------
module vau_front import vau_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int LANES     = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [2:0]       cmd,
  input  logic [2:0]       vec_size,
  input  logic             scalar_mode,
  input  logic [3:0][31:0] a,
  input  logic [3:0][31:0] b,
  output logic             out_valid,
  output vau_item_t        out_item
);

  localparam logic [2:0] NMAX = 3'(LANES);
  localparam logic signed [66:0] HALF = 67'sd1 <<< (FRAC_BITS - 1);

  // Round to nearest, ties upward, at the binary point
  function automatic logic signed [66:0] rnd(input logic signed [65:0] v);
    return (67'(v) + HALF) >>> FRAC_BITS;
  endfunction

  // Stage 1 registers
  logic                v1_r;
  vau_cmd_t            cmd1_r;
  logic [3:0]          act1_r;
  logic signed [31:0]  a1_r [4];
  logic signed [31:0]  b1_r [4];
  logic signed [63:0]  p1_r [6];

  // Stage 2 registers
  logic                v2_r;
  vau_item_t           item2_r, item2_nxt;
  logic signed [64:0]  s01_r, s23_r, s45_r;

  // Stage 3 registers
  logic                v3_r;
  vau_item_t           item3_r, item3_nxt;
  logic signed [65:0]  tot3_r;

  // Stage 4 registers
  logic                v4_r;
  vau_item_t           item4_r, item4_nxt;

  vau_cmd_t            cmd_e;
  logic [2:0]          nsz;
  logic [3:0]          act;
  logic signed [31:0]  av [4];
  logic signed [31:0]  bv [4];
  logic signed [31:0]  ma [6];
  logic signed [31:0]  mb [6];

  // Decode size and operands, pick multiplier inputs
  always_comb begin
    cmd_e = vau_cmd_t'(cmd);
    if (vec_size < 3'd2) begin
      nsz = 3'd2;
    end else if (vec_size > NMAX) begin
      nsz = NMAX;
    end else begin
      nsz = vec_size;
    end
    for (int i = 0; i < 4; i++) begin
      act[i] = (3'(i) < nsz);
      av[i]  = $signed(a[i]);
      if (scalar_mode && (cmd_e == CMD_ADD || cmd_e == CMD_SUB ||
                          cmd_e == CMD_MUL || cmd_e == CMD_DIV)) begin
        bv[i] = $signed(b[0]);
      end else begin
        bv[i] = $signed(b[i]);
      end
    end
    for (int k = 0; k < 6; k++) begin
      ma[k] = '0;
      mb[k] = '0;
    end
    case (cmd_e)
      CMD_CROSS: begin
        ma[0] = av[1]; mb[0] = bv[2];
        ma[1] = av[2]; mb[1] = bv[1];
        ma[2] = av[2]; mb[2] = bv[0];
        ma[3] = av[0]; mb[3] = bv[2];
        ma[4] = av[0]; mb[4] = bv[1];
        ma[5] = av[1]; mb[5] = bv[0];
      end
      CMD_MUL, CMD_DOT: begin
        for (int i = 0; i < 4; i++) begin
          if (act[i]) begin
            ma[i] = av[i];
            mb[i] = bv[i];
          end
        end
      end
      CMD_LEN: begin
        for (int i = 0; i < 4; i++) begin
          if (act[i]) begin
            ma[i] = av[i];
            mb[i] = av[i];
          end
        end
      end
      CMD_NORM: begin
        for (int i = 0; i < 3; i++) begin
          ma[i] = av[i];
          mb[i] = av[i];
        end
      end
      default: begin
      end
    endcase
  end

  // Stage 1: products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
    if (en) begin
      cmd1_r <= cmd_e;
      act1_r <= act;
      for (int i = 0; i < 4; i++) begin
        a1_r[i] <= av[i];
        b1_r[i] <= bv[i];
      end
      for (int k = 0; k < 6; k++) begin
        p1_r[k] <= ma[k] * mb[k];
      end
    end
  end

  // Stage 2: elementwise results, divider set-up and partial sums
  always_comb begin
    logic signed [32:0] es;
    vau_sat_t           st;
    item2_nxt     = '0;
    item2_nxt.cmd = cmd1_r;
    for (int i = 0; i < 4; i++) begin
      es = '0;
      st = '0;
      case (cmd1_r)
        CMD_ADD, CMD_SUB: begin
          if (act1_r[i]) begin
            es = (cmd1_r == CMD_ADD) ? 33'(a1_r[i]) + 33'(b1_r[i])
                                     : 33'(a1_r[i]) - 33'(b1_r[i]);
            st = vau_sat(67'(es));
            item2_nxt.r[i] = st.val;
            item2_nxt.ovf  = item2_nxt.ovf | st.ovf;
          end
        end
        CMD_MUL: begin
          if (act1_r[i]) begin
            st = vau_sat(rnd(66'(p1_r[i])));
            item2_nxt.r[i] = st.val;
            item2_nxt.ovf  = item2_nxt.ovf | st.ovf;
          end
        end
        CMD_DIV: begin
          if (act1_r[i]) begin
            if (b1_r[i] == 32'sd0) begin
              item2_nxt.dz = 1'b1;
              if (a1_r[i] > 32'sd0) begin
                item2_nxt.r[i] = MAX32;
              end else if (a1_r[i] < 32'sd0) begin
                item2_nxt.r[i] = MIN32;
              end
            end else begin
              item2_nxt.dmask[i]   = 1'b1;
              item2_nxt.num_neg[i] = a1_r[i][31];
              item2_nxt.den_neg[i] = b1_r[i][31];
              item2_nxt.num_mag[i] = vau_mag(a1_r[i]);
              item2_nxt.den_mag[i] = {1'b0, vau_mag(b1_r[i])};
            end
          end
        end
        CMD_NORM: begin
          // Hold the input as the answer for a zero length
          if (i < 3) begin
            item2_nxt.r[i]       = a1_r[i];
            item2_nxt.num_neg[i] = a1_r[i][31];
            item2_nxt.num_mag[i] = vau_mag(a1_r[i]);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
    if (en) begin
      item2_r <= item2_nxt;
      if (cmd1_r == CMD_CROSS) begin
        s01_r <= 65'(p1_r[0]) - 65'(p1_r[1]);
        s23_r <= 65'(p1_r[2]) - 65'(p1_r[3]);
      end else begin
        s01_r <= 65'(p1_r[0]) + 65'(p1_r[1]);
        s23_r <= 65'(p1_r[2]) + 65'(p1_r[3]);
      end
      s45_r <= 65'(p1_r[4]) - 65'(p1_r[5]);
    end
  end

  // Stage 3: cross rounding, full sum
  always_comb begin
    vau_sat_t sx, sy, sz;
    item3_nxt = item2_r;
    sx = vau_sat(rnd(66'(s01_r)));
    sy = vau_sat(rnd(66'(s23_r)));
    sz = vau_sat(rnd(66'(s45_r)));
    if (item2_r.cmd == CMD_CROSS) begin
      item3_nxt.r[0] = sx.val;
      item3_nxt.r[1] = sy.val;
      item3_nxt.r[2] = sz.val;
      item3_nxt.ovf  = sx.ovf | sy.ovf | sz.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
    if (en) begin
      item3_r <= item3_nxt;
      tot3_r  <= 66'(s01_r) + 66'(s23_r);
    end
  end

  // Stage 4: dot rounding, length and normalize set-up
  always_comb begin
    vau_sat_t sd;
    item4_nxt = item3_r;
    sd = vau_sat(rnd(tot3_r));
    case (item3_r.cmd)
      CMD_DOT: begin
        item4_nxt.r[0] = sd.val;
        item4_nxt.ovf  = sd.ovf;
      end
      CMD_LEN: begin
        item4_nxt.sq_sum = tot3_r[63:0];
        if (tot3_r[65:64] != 2'b00) begin
          item4_nxt.r[0] = MAX32;
          item4_nxt.ovf  = 1'b1;
        end else begin
          item4_nxt.len_sel = 1'b1;
        end
      end
      CMD_NORM: begin
        item4_nxt.sq_sum = tot3_r[63:0];
        if (tot3_r != 66'sd0) begin
          item4_nxt.norm_sel = 1'b1;
          item4_nxt.dmask    = 4'b0111;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
    if (en) begin
      item4_r <= item4_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_item  = item4_r;

endmodule

// File: src/vau_sqrt.sv
// ----------------------------------------------------------------------------
// Vector arithmetic unit square root
// Pipelined digit-by-digit root of a 64-bit radicand, one root bit per
// stage; the final remainder comes out for rounding.
// ----------------------------------------------------------------------------
module vau_sqrt import vau_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  vau_item_t   in_item,
  output logic        out_valid,
  output vau_item_t   out_item,
  output logic [31:0] root,
  output logic [33:0] rem
);

  logic              v_r   [SQ_STAGES];
  vau_item_t         it_r  [SQ_STAGES];
  logic [31:0]       rt_r  [SQ_STAGES];
  logic [33:0]       rm_r  [SQ_STAGES];
  logic [63:0]       sv_r  [SQ_STAGES];
  logic [31:0]       rt_nxt[SQ_STAGES];
  logic [33:0]       rm_nxt[SQ_STAGES];
  logic [63:0]       sv_nxt[SQ_STAGES];

  // Bring down two radicand bits, try the next root bit
  always_comb begin
    logic [31:0] rt_i;
    logic [33:0] rm_i;
    logic [63:0] sv_i;
    logic [35:0] t;
    logic [35:0] trial;
    logic [35:0] diff;
    for (int k = 0; k < SQ_STAGES; k++) begin
      if (k == 0) begin
        rt_i = '0;
        rm_i = '0;
        sv_i = in_item.sq_sum;
      end else begin
        rt_i = rt_r[k-1];
        rm_i = rm_r[k-1];
        sv_i = sv_r[k-1];
      end
      t     = {rm_i, sv_i[63:62]};
      trial = {2'b00, rt_i, 2'b01};
      diff  = t - trial;
      if (t >= trial) begin
        rm_nxt[k] = diff[33:0];
        rt_nxt[k] = {rt_i[30:0], 1'b1};
      end else begin
        rm_nxt[k] = t[33:0];
        rt_nxt[k] = {rt_i[30:0], 1'b0};
      end
      sv_nxt[k] = {sv_i[61:0], 2'b00};
    end
  end

  // Advance every stage together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SQ_STAGES; k++) begin
        v_r[k] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int k = 1; k < SQ_STAGES; k++) begin
        v_r[k] <= v_r[k-1];
      end
    end
    if (en) begin
      it_r[0] <= in_item;
      for (int k = 1; k < SQ_STAGES; k++) begin
        it_r[k] <= it_r[k-1];
      end
      for (int k = 0; k < SQ_STAGES; k++) begin
        rt_r[k] <= rt_nxt[k];
        rm_r[k] <= rm_nxt[k];
        sv_r[k] <= sv_nxt[k];
      end
    end
  end

  assign out_valid = v_r[SQ_STAGES-1];
  assign out_item  = it_r[SQ_STAGES-1];
  assign root      = rt_r[SQ_STAGES-1];
  assign rem       = rm_r[SQ_STAGES-1];

endmodule

// File: src/vau_div.sv
// ----------------------------------------------------------------------------
// Vector arithmetic unit divider
// Four-lane pipelined restoring divider on magnitudes: dividend shifted up
// by the fraction width, one quotient bit per stage.
// ----------------------------------------------------------------------------
module vau_div import vau_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  vau_item_t                   in_item,
  output logic                        out_valid,
  output vau_item_t                   out_item,
  output logic [3:0][32+FRAC_BITS-1:0] quo
);

  localparam int DW = 32 + FRAC_BITS;

  logic            v_r   [DW];
  vau_item_t       it_r  [DW];
  logic [DW-1:0]   wk_r  [DW][4];
  logic [32:0]     rm_r  [DW][4];
  logic [DW-1:0]   wk_nxt[DW][4];
  logic [32:0]     rm_nxt[DW][4];

  // Shift in one dividend bit per lane, subtract where the divisor fits
  always_comb begin
    logic [DW-1:0] wk_i;
    logic [32:0]   rm_i;
    logic [32:0]   den;
    logic [33:0]   t;
    logic [33:0]   diff;
    for (int k = 0; k < DW; k++) begin
      for (int j = 0; j < 4; j++) begin
        if (k == 0) begin
          wk_i = {in_item.num_mag[j], FRAC_BITS'(0)};
          rm_i = '0;
          den  = in_item.den_mag[j];
        end else begin
          wk_i = wk_r[k-1][j];
          rm_i = rm_r[k-1][j];
          den  = it_r[k-1].den_mag[j];
        end
        t    = {rm_i, wk_i[DW-1]};
        diff = t - {1'b0, den};
        if (t >= {1'b0, den}) begin
          rm_nxt[k][j] = diff[32:0];
          wk_nxt[k][j] = {wk_i[DW-2:0], 1'b1};
        end else begin
          rm_nxt[k][j] = t[32:0];
          wk_nxt[k][j] = {wk_i[DW-2:0], 1'b0};
        end
      end
    end
  end

  // Advance every stage together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DW; k++) begin
        v_r[k] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int k = 1; k < DW; k++) begin
        v_r[k] <= v_r[k-1];
      end
    end
    if (en) begin
      it_r[0] <= in_item;
      for (int k = 1; k < DW; k++) begin
        it_r[k] <= it_r[k-1];
      end
      for (int k = 0; k < DW; k++) begin
        for (int j = 0; j < 4; j++) begin
          wk_r[k][j] <= wk_nxt[k][j];
          rm_r[k][j] <= rm_nxt[k][j];
        end
      end
    end
  end

  assign out_valid = v_r[DW-1];
  assign out_item  = it_r[DW-1];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      quo[j] = wk_r[DW-1][j];
    end
  end

endmodule

// File: tb/sv/tb_vector_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector arithmetic unit testbench
// Drives a short table of directed vectors and then about 1450 random
// transactions through the Q16.16 vector ALU, with random idling on both
// channels and one long result-side hold-off. Every result is compared field
// by field with a typed table entry or a behavioural Q16.16 calculation.
// ----------------------------------------------------------------------------
module tb_vector_arithmetic_unit;
  import vau_pkg::*;

  localparam int          NUM_RANDOM = 1450;
  localparam int          DRAIN_WAIT = 120;
  localparam int          HOLD_LEN   = 300;
  localparam logic [31:0] ONE_Q      = 32'h0001_0000;

  typedef struct packed {
    vau_cmd_t         cmd;
    logic [2:0]       size;
    logic             scalar;
    logic [3:0][31:0] a;      // index 0 is x
    logic [3:0][31:0] b;
  } vec_op_t;

  typedef struct packed {
    logic [3:0][31:0] r;
    logic             dz;
    logic             ovf;
  } vec_res_t;

  typedef struct packed {
    vec_op_t  op;
    logic     typed;          // expected result given in the table
    vec_res_t res;
  } vec_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_cmd = '0;
  logic [2:0]  in_vec_size = 3'd2;
  logic        in_scalar_mode = 1'b0;
  logic [31:0] in_a_x = '0, in_a_y = '0, in_a_z = '0, in_a_w = '0;
  logic [31:0] in_b_x = '0, in_b_y = '0, in_b_z = '0, in_b_w = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_r_x, out_r_y, out_r_z, out_r_w;
  logic        out_div_zero, out_overflow;

  vec_res_t    pending_results[$];
  vec_row_t    directed_rows[$];
  int          error_count = 0;
  int          send_idle_pct = 33;
  int          recv_idle_pct = 45;
  bit          hold_request = 1'b0;
  bit          hold_done = 1'b0;
  int          hold_cycles = 0;

  vector_arithmetic_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_cmd(in_cmd), .in_vec_size(in_vec_size), .in_scalar_mode(in_scalar_mode),
    .in_a_x(in_a_x), .in_a_y(in_a_y), .in_a_z(in_a_z), .in_a_w(in_a_w),
    .in_b_x(in_b_x), .in_b_y(in_b_y), .in_b_z(in_b_z), .in_b_w(in_b_w),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_r_x(out_r_x), .out_r_y(out_r_y), .out_r_z(out_r_z), .out_r_w(out_r_w),
    .out_div_zero(out_div_zero), .out_overflow(out_overflow)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Clip a wide value to 32 bits, noting saturation
  function automatic logic [31:0] clip32(input logic signed [127:0] v, inout logic ovf);
    if (v > 128'sd2147483647) begin
      ovf = 1'b1;
      return MAX32;
    end
    if (v < -128'sd2147483648) begin
      ovf = 1'b1;
      return MIN32;
    end
    return v[31:0];
  endfunction

  // Square root rounded to nearest
  function automatic logic [127:0] root_nearest(input logic [127:0] s);
    logic [127:0] r, t;
    r = '0;
    for (int k = 31; k >= 0; k--) begin
      t = r | (128'd1 << k);
      if (t * t <= s) r = t;
    end
    if (s - r * r > r) r = r + 1;
    return r;
  endfunction

  // Round an exact Q32.32 sum to Q16.16, ties toward +infinity
  function automatic logic signed [127:0] round_q(input logic signed [127:0] v);
    return (v + 128'sd32768) >>> 16;
  endfunction

  // Work out the result of one vector command
  function automatic vec_res_t compute_vector(input vec_op_t op);
    vec_res_t              res;
    logic signed [127:0]   av[4], bv[4], acc, q;
    logic [127:0]          sum, len;
    int                    n;
    res = '0;
    n = (op.size < 2) ? 2 : ((op.size > 4) ? 4 : op.size);
    for (int i = 0; i < 4; i++) begin
      av[i] = signed'(op.a[i]);
      bv[i] = signed'(op.b[i]);
    end
    if (op.scalar && op.cmd inside {CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV})
      for (int i = 1; i < 4; i++) bv[i] = bv[0];
    case (op.cmd)
      CMD_ADD, CMD_SUB: begin
        for (int i = 0; i < n; i++)
          res.r[i] = clip32(op.cmd == CMD_ADD ? av[i] + bv[i] : av[i] - bv[i], res.ovf);
      end
      CMD_MUL: begin
        for (int i = 0; i < n; i++) res.r[i] = clip32(round_q(av[i] * bv[i]), res.ovf);
      end
      CMD_DIV: begin
        for (int i = 0; i < n; i++) begin
          if (bv[i] == 0) begin
            res.dz = 1'b1;
            res.r[i] = (av[i] > 0) ? MAX32 : ((av[i] < 0) ? MIN32 : 32'd0);
          end else begin
            q = (av[i] * 65536) / bv[i];
            res.r[i] = clip32(q, res.ovf);
          end
        end
      end
      CMD_CROSS: begin
        res.r[0] = clip32(round_q(av[1] * bv[2] - av[2] * bv[1]), res.ovf);
        res.r[1] = clip32(round_q(av[2] * bv[0] - av[0] * bv[2]), res.ovf);
        res.r[2] = clip32(round_q(av[0] * bv[1] - av[1] * bv[0]), res.ovf);
      end
      CMD_DOT: begin
        acc = '0;
        for (int i = 0; i < n; i++) acc = acc + av[i] * bv[i];
        res.r[0] = clip32(round_q(acc), res.ovf);
      end
      CMD_LEN: begin
        sum = '0;
        for (int i = 0; i < n; i++) sum = sum + unsigned'(av[i] * av[i]);
        if (sum >= (128'd1 << 64)) begin
          res.ovf = 1'b1;
          res.r[0] = MAX32;
        end else begin
          res.r[0] = clip32(signed'(root_nearest(sum)), res.ovf);
        end
      end
      default: begin
        sum = '0;
        for (int i = 0; i < 3; i++) sum = sum + unsigned'(av[i] * av[i]);
        if (sum == 0) begin
          for (int i = 0; i < 3; i++) res.r[i] = op.a[i];
        end else begin
          len = root_nearest(sum);
          for (int i = 0; i < 3; i++) begin
            q = (av[i] * 65536) / signed'(len);
            res.r[i] = clip32(q, res.ovf);
          end
        end
      end
    endcase
    return res;
  endfunction

  function automatic void add_row(input vau_cmd_t cmd, input logic [2:0] size,
                                  input logic scalar, input logic [3:0][31:0] a,
                                  input logic [3:0][31:0] b, input logic typed,
                                  input vec_res_t res);
    vec_row_t row;
    row.op = '{cmd: cmd, size: size, scalar: scalar, a: a, b: b};
    row.typed = typed;
    row.res = res;
    directed_rows.push_back(row);
  endfunction

  // Operand values biased toward extremes and small magnitudes
  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0: return MAX32;
      1: return MIN32;
      2: return '0;
      3: return $urandom_range(1) ? 32'd1 : 32'hffff_ffff;
      4, 5: return 32'($signed($urandom_range(2097152)) - 1048576);
      6: return $urandom_range(1) ? ONE_Q : -ONE_Q;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, field, got, want);
    error_count++;
  endtask

  // Offer one transaction and hold it until accepted
  task automatic send_op(input vec_op_t op, input vec_res_t want);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_cmd         <= op.cmd;
    in_vec_size    <= op.size;
    in_scalar_mode <= op.scalar;
    in_a_x <= op.a[0]; in_a_y <= op.a[1]; in_a_z <= op.a[2]; in_a_w <= op.a[3];
    in_b_x <= op.b[0]; in_b_y <= op.b[1]; in_b_z <= op.b[2]; in_b_w <= op.b[3];
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(want);
    @(negedge clk);
  endtask

  // Result side readiness, with one long hold-off on request
  always @(negedge clk) begin
    if (hold_request && !hold_done) begin
      hold_cycles = HOLD_LEN;
      hold_done = 1'b1;
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check each result transaction against the oldest expectation
  always @(posedge clk) begin
    vec_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected", $realtime);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_r_x !== want.r[0]) report_mismatch("r_x", out_r_x, want.r[0]);
        if (out_r_y !== want.r[1]) report_mismatch("r_y", out_r_y, want.r[1]);
        if (out_r_z !== want.r[2]) report_mismatch("r_z", out_r_z, want.r[2]);
        if (out_r_w !== want.r[3]) report_mismatch("r_w", out_r_w, want.r[3]);
        if (out_div_zero !== want.dz) report_mismatch("div_zero", out_div_zero, want.dz);
        if (out_overflow !== want.ovf) report_mismatch("overflow", out_overflow, want.ovf);
      end
    end
  end

  initial begin
    #(4ns * 400000);
    $display("Verification failed");
    $finish;
  end

  initial begin
    vec_op_t  op;
    vec_res_t want;
    // Packed vectors below are written {w, z, y, x}
    add_row(CMD_ADD, 3'd4, 1'b0, {32'd4, 32'd3, 32'd2, 32'd1},
            {32'd40, 32'd30, 32'd20, 32'd10}, 1'b1, '{r: {32'd44, 32'd33, 32'd22, 32'd11},
            dz: 1'b0, ovf: 1'b0});
    add_row(CMD_ADD, 3'd4, 1'b1, {MAX32, MAX32, MAX32, MAX32},
            {32'd0, 32'd0, 32'd0, 32'd1}, 1'b1,
            '{r: {MAX32, MAX32, MAX32, MAX32}, dz: 1'b0, ovf: 1'b1});
    add_row(CMD_SUB, 3'd2, 1'b0, {MIN32, MIN32, MIN32, MIN32}, {32'd1, 32'd1, 32'd1, 32'd1},
            1'b1, '{r: {32'd0, 32'd0, MIN32, MIN32}, dz: 1'b0, ovf: 1'b1});
    add_row(CMD_MUL, 3'd2, 1'b0, {32'd0, 32'd0, 32'd0, ONE_Q},
            {32'd0, 32'd0, 32'd0, 32'h0002_0000}, 1'b1,
            '{r: {32'd0, 32'd0, 32'd0, 32'h0002_0000}, dz: 1'b0, ovf: 1'b0});
    add_row(CMD_MUL, 3'd4, 1'b0, {MIN32, MAX32, MIN32, MAX32}, {MIN32, MIN32, MAX32, MAX32},
            1'b0, '0);
    add_row(CMD_MUL, 3'd3, 1'b1, {32'd1, 32'h8000, 32'hffff_8000, 32'h7fff},
            {32'd0, 32'd0, 32'd0, 32'd1}, 1'b0, '0);
    add_row(CMD_DIV, 3'd4, 1'b0, {32'd7, 32'd0, -32'd5, 32'd5}, '0, 1'b1,
            '{r: {MAX32, 32'd0, MIN32, MAX32}, dz: 1'b1, ovf: 1'b0});
    add_row(CMD_DIV, 3'd4, 1'b0, {32'd3, ONE_Q, MAX32, MIN32},
            {32'd2, -ONE_Q, 32'd1, 32'hffff_ffff}, 1'b0, '0);
    add_row(CMD_DIV, 3'd2, 1'b1, {32'd9, 32'd9, -ONE_Q, ONE_Q},
            {32'd0, 32'd0, 32'd0, 32'h0003_0000}, 1'b0, '0);
    add_row(CMD_CROSS, 3'd4, 1'b1, {32'd0, 32'h0003_0000, 32'h0002_0000, ONE_Q},
            {32'd5, 32'h0006_0000, 32'h0005_0000, 32'h0004_0000}, 1'b0, '0);
    add_row(CMD_CROSS, 3'd3, 1'b0, {MAX32, MIN32, MAX32, MIN32}, {MIN32, MAX32, MIN32, MAX32},
            1'b0, '0);
    add_row(CMD_DOT, 3'd4, 1'b0, {32'd4, 32'd3, 32'd2, 32'd1}, {32'd1, 32'd2, 32'd3, 32'd4},
            1'b0, '0);
    add_row(CMD_DOT, 3'd4, 1'b0, {MIN32, MIN32, MIN32, MIN32}, {MIN32, MIN32, MIN32, MIN32},
            1'b0, '0);
    add_row(CMD_LEN, 3'd2, 1'b0, {32'd0, 32'd0, 32'h0004_0000, 32'h0003_0000}, '0, 1'b1,
            '{r: {32'd0, 32'd0, 32'd0, 32'h0005_0000}, dz: 1'b0, ovf: 1'b0});
    add_row(CMD_LEN, 3'd4, 1'b0, {MIN32, MIN32, MIN32, MIN32}, '0, 1'b1,
            '{r: {32'd0, 32'd0, 32'd0, MAX32}, dz: 1'b0, ovf: 1'b1});
    add_row(CMD_LEN, 3'd3, 1'b1, {MAX32, MAX32, MAX32, MAX32}, '0, 1'b0, '0);
    add_row(CMD_NORM, 3'd4, 1'b0, {32'd9, 32'd0, 32'd0, 32'd0}, '0, 1'b1, '0);
    add_row(CMD_NORM, 3'd2, 1'b0, {32'd1, 32'h0004_0000, 32'h0003_0000, ONE_Q}, '0, 1'b0, '0);
    add_row(CMD_NORM, 3'd4, 1'b0, {32'd0, 32'd0, 32'd0, 32'd1}, {MAX32, MAX32, MAX32, MAX32},
            1'b0, '0);
    // Sizes outside two to four clamp to the nearest bound
    add_row(CMD_ADD, 3'd0, 1'b0, {32'd4, 32'd3, 32'd2, 32'd1}, {32'd4, 32'd3, 32'd2, 32'd1},
            1'b0, '0);
    add_row(CMD_SUB, 3'd1, 1'b0, {32'd4, 32'd3, 32'd2, 32'd1}, '0, 1'b0, '0);
    add_row(CMD_DOT, 3'd7, 1'b0, {ONE_Q, ONE_Q, ONE_Q, ONE_Q}, {ONE_Q, ONE_Q, ONE_Q, ONE_Q},
            1'b0, '0);
    add_row(CMD_LEN, 3'd5, 1'b0, {ONE_Q, ONE_Q, ONE_Q, ONE_Q}, '0, 1'b0, '0);

    // Hold reset, then release it on a falling clock edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[k]) begin
      want = directed_rows[k].typed ? directed_rows[k].res : compute_vector(directed_rows[k].op);
      send_op(directed_rows[k].op, want);
    end

    for (int k = 0; k < NUM_RANDOM; k++) begin
      if (k == NUM_RANDOM / 3) begin
        send_idle_pct = 45;
        recv_idle_pct = 33;
      end else if (k == 2 * NUM_RANDOM / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 1'b1;
      end
      op.cmd    = vau_cmd_t'($urandom_range(7));
      op.size   = $urandom_range(3) == 0 ? 3'($urandom_range(7)) : 3'($urandom_range(2, 4));
      op.scalar = 1'($urandom_range(1));
      for (int i = 0; i < 4; i++) begin
        op.a[i] = pick_value();
        op.b[i] = pick_value();
      end
      send_op(op, compute_vector(op));
    end
    in_valid <= 1'b0;

    // Drain, then allow the pipeline latency for any stray result
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
